>>> rtl/core/tlpa_pkg.sv
// ----------------------------------------------------------------------------
// tlpa_pkg
// Shared types and codes for the two-lane priority/age arbiter.
// ----------------------------------------------------------------------------
package tlpa_pkg;

	localparam int ID_W    = 8;
	localparam int PRIO_W  = 2;
	localparam int STAMP_W = 16;
	localparam int QCNT_W  = 6;

	// operation codes
	localparam logic OP_ENQ   = 1'b0;
	localparam logic OP_GRANT = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// one stored request
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic               lane;
		logic [PRIO_W-1:0]  prio;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// finished transaction handed from the sequencer to the output register
	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   gid;
		logic              glane;
		logic [PRIO_W-1:0] gprio;
		logic [QCNT_W-1:0] qcount;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_SHIFT,
		S_RESULT
	} fsm_state_t;

endpackage

>>> rtl/core/tlpa_ram.sv
// ----------------------------------------------------------------------------
// tlpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlpa_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/tlpa_pick.sv
// ----------------------------------------------------------------------------
// tlpa_pick
// Chooses between the oldest request of each lane: priority, then wrapped age.
// ----------------------------------------------------------------------------
module tlpa_pick (
	input  tlpa_pkg::entry_t ent0,
	input  tlpa_pkg::entry_t ent1,
	input  logic             found0,
	input  logic             found1,
	output logic             take1
);
	import tlpa_pkg::*;

	logic [STAMP_W-1:0] diff;
	logic               lane0_wins;

	always_comb begin
		// stamp a is older than b when a - b (mod 2^16) is negative
		diff       = ent0.stamp - ent1.stamp;
		lane0_wins = (ent0.prio > ent1.prio) ||
			((ent0.prio == ent1.prio) && diff[STAMP_W-1]);
		take1      = !found0 || (found1 && !lane0_wins);
	end

endmodule

>>> rtl/core/tlpa_ctrl.sv
// ----------------------------------------------------------------------------
// tlpa_ctrl
// Sequencer: enqueue write, lane scan, winner pick and compaction shift.
// ----------------------------------------------------------------------------
module tlpa_ctrl #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          op,
	input  logic [tlpa_pkg::ID_W-1:0]     id,
	input  logic                          lane,
	input  logic [tlpa_pkg::PRIO_W-1:0]   prio,
	output logic                          idle,
	output logic                          res_valid,
	output tlpa_pkg::res_t                res,
	input  logic                          res_take
);
	import tlpa_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fsm_state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [STAMP_W-1:0] arr_q;
	logic [CW-1:0]      idx_q;
	logic               rv_q;
	logic [CW-1:0]      ri_q;
	logic               found0_q, found1_q;
	entry_t             ent0_q, ent1_q;
	logic [CW-1:0]      pos0_q, pos1_q;
	entry_t             res_ent_q;
	logic [1:0]         res_status_q;

	logic               full;
	logic               issue;
	logic               take1;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;
	entry_t             rd_ent;

	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign rd_ent = entry_t'(mem_rdata);

	tlpa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	tlpa_pick u_pick (
		.ent0  (ent0_q),
		.ent1  (ent1_q),
		.found0(found0_q),
		.found1(found1_q),
		.take1 (take1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		issue     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = '{id: id, lane: lane, prio: prio, stamp: arr_q};
		mem_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					if (op == OP_ENQ) begin
						mem_we  = !full;
						state_d = S_RESULT;
					end else if (count_q == '0) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// stop issuing once both lane heads are known
				issue = (idx_q < count_q) && !(found0_q && found1_q);
				if (!issue && !rv_q) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				// read entry i+1, write it back to i in the following cycle
				issue = (idx_q < count_q);
				if (rv_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(ri_q - CW'(1));
					mem_wdata = rd_ent;
				end
				if (!issue && !rv_q) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			arr_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= issue;
			if (state_q == S_IDLE && start && op == OP_ENQ && !full) begin
				count_q <= count_q + CW'(1);
				arr_q   <= arr_q + STAMP_W'(1);
			end
			if (state_q == S_SHIFT && state_d == S_RESULT) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// scan and result payload
	always_ff @(posedge clk) begin
		ri_q <= idx_q;
		if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_ent_q <= '0;
					found0_q  <= 1'b0;
					found1_q  <= 1'b0;
					idx_q     <= '0;
					if (op == OP_ENQ) begin
						res_status_q <= full ? STATUS_FULL : STATUS_DONE;
					end else begin
						res_status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_DONE;
					end
				end
			end
			S_SCAN: begin
				if (rv_q) begin
					if (!rd_ent.lane && !found0_q) begin
						found0_q <= 1'b1;
						ent0_q   <= rd_ent;
						pos0_q   <= ri_q;
					end
					if (rd_ent.lane && !found1_q) begin
						found1_q <= 1'b1;
						ent1_q   <= rd_ent;
						pos1_q   <= ri_q;
					end
				end
			end
			S_PICK: begin
				if (take1) begin
					res_ent_q <= ent1_q;
					idx_q     <= pos1_q + CW'(1);
				end else begin
					res_ent_q <= ent0_q;
					idx_q     <= pos0_q + CW'(1);
				end
			end
			S_SHIFT, S_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.status = res_status_q;
		res.gid    = res_ent_q.id;
		res.glane  = res_ent_q.lane;
		res.gprio  = res_ent_q.prio;
		res.qcount = QCNT_W'(count_q);
	end

endmodule

>>> rtl/core/two_lane_priority_age_arbiter.sv
// ----------------------------------------------------------------------------
// two_lane_priority_age_arbiter
// Shared request store for two lanes; grants the better lane head by
// priority, ties broken by wrapped arrival stamp.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | transaction when
//  --------+------------------------------------------------+-----------------
//  in      | in_valid/in_ready, operation, train_id,        | in_valid & in_ready
//          | entry_lane, priority_level                     |
//  out     | out_valid/out_ready, status, granted_id,       | out_valid & out_ready
//          | granted_lane, granted_priority, queue_count    |
//
//  Enqueue: store write, then result into the output register.
//  Grant: the lane-head scan and the compaction shift both go through the
//    single read port of the store, one entry per cycle.
//  Empty grant: straight to the result, with no scan or shift.
//  Reset clears count, arrival stamp and handshake state; store contents
//    stay undefined, only entries below the count are ever read.
//  A new transaction is taken while the previous result still waits in the
//    output register; a stalled output holds only the final result step.
//
module two_lane_priority_age_arbiter #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [tlpa_pkg::ID_W-1:0]   train_id,
	input  logic                        entry_lane,
	input  logic [tlpa_pkg::PRIO_W-1:0] priority_level,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [tlpa_pkg::ID_W-1:0]   granted_id,
	output logic                        granted_lane,
	output logic [tlpa_pkg::PRIO_W-1:0] granted_priority,
	output logic [tlpa_pkg::QCNT_W-1:0] queue_count
);
	import tlpa_pkg::*;

	logic   idle;
	logic   res_valid;
	logic   res_take;
	res_t   res;
	logic   out_valid_q;
	res_t   out_q;

	// sequencer only takes a transaction while idle
	assign in_ready = idle;

	// output register frees up when empty or drained this cycle
	assign res_take = !out_valid_q || out_ready;

	tlpa_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && idle),
		.op       (operation),
		.id       (train_id),
		.lane     (entry_lane),
		.prio     (priority_level),
		.idle     (idle),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign granted_id       = out_q.gid;
	assign granted_lane     = out_q.glane;
	assign granted_priority = out_q.gprio;
	assign queue_count      = out_q.qcount;

endmodule

>>> rtl/core/tlpa_checker.sv
// ----------------------------------------------------------------------------
// tlpa_checker
// Port-level checks for the arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module tlpa_checker #(
	parameter int QUEUE_DEPTH = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  status,
	input logic [tlpa_pkg::ID_W-1:0]   granted_id,
	input logic                        granted_lane,
	input logic [tlpa_pkg::PRIO_W-1:0] granted_priority,
	input logic [tlpa_pkg::QCNT_W-1:0] queue_count
);
	import tlpa_pkg::*;

	localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH % 64);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_id) && $stable(queue_count))
		else $error("stalled result changed");

	// an accepted transaction keeps the sequencer busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_DONE) || (status == STATUS_FULL) ||
		(status == STATUS_EMPTY))
		else $error("bad status code");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |-> granted_id == '0 &&
		!granted_lane && granted_priority == '0 && queue_count == '0)
		else $error("empty grant result not clean");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |-> queue_count == FULL_CNT &&
		granted_id == '0)
		else $error("full result with wrong count");

endmodule

bind two_lane_priority_age_arbiter tlpa_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_tlpa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.granted_id      (granted_id),
	.granted_lane    (granted_lane),
	.granted_priority(granted_priority),
	.queue_count     (queue_count)
);
